>>> rtl/core/sbrp_pkg.sv
// ----------------------------------------------------------------------------
// sbrp_pkg
// Shared types and constants for the binding response parser.
// ----------------------------------------------------------------------------
package sbrp_pkg;

  localparam logic [15:0] MSG_TYPE_BIND_RESP = 16'h0101;
  localparam logic [31:0] STUN_COOKIE        = 32'h2112A442;
  localparam logic [15:0] COOKIE_HI          = 16'h2112;
  localparam logic [15:0] ATTR_MAPPED        = 16'h0001;
  localparam logic [15:0] ATTR_XOR_MAPPED    = 16'h0020;
  localparam logic [7:0]  FAMILY_IPV4        = 8'h01;
  localparam logic [4:0]  HDR_BYTES          = 5'd20;

  localparam logic [2:0] ST_FOUND  = 3'd0;
  localparam logic [2:0] ST_TYPE   = 3'd1;
  localparam logic [2:0] ST_COOKIE = 3'd2;
  localparam logic [2:0] ST_ID     = 3'd3;
  localparam logic [2:0] ST_NOADDR = 3'd4;
  localparam logic [2:0] ST_TRUNC  = 3'd5;

  typedef enum logic [1:0] {
    CFG_TXID_HEAD = 2'd0,
    CFG_TXID_TAIL = 2'd1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE     = 3'd0,
    PH_HEADER   = 3'd1,
    PH_ATTR_HDR = 3'd2,
    PH_ATTR_VAL = 3'd3,
    PH_DONE     = 3'd4
  } phase_e;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       first_byte;
    logic       last_byte;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        address_kind;
    logic [31:0] ipv4_address;
    logic [15:0] port_number;
  } out_t;

  typedef struct packed {
    phase_e      phase;
    logic [4:0]  hdr_idx;
    logic [15:0] msg_len;
    logic [15:0] body_cnt;
    logic [15:0] attr_type;
    logic [15:0] attr_len;
    logic [15:0] attr_off;
    logic [7:0]  family;
    logic [15:0] port;
    logic [31:0] addr;
  } parse_st_t;

endpackage

>>> rtl/core/stun_binding_response_parser.sv
// ----------------------------------------------------------------------------
// stun_binding_response_parser
// Byte-wide STUN binding response checker and mapped address extractor.
// ----------------------------------------------------------------------------
// Takes one message byte per cycle with no gaps of its own: a byte is
// registered, walked through the header and attribute logic, and any verdict
// is passed from that byte register on into the result register. Only
// a full result register that the consumer does not drain holds off input.
// At most one verdict (found, wrong type, bad cookie, id mismatch, no
// address, truncated) comes out per message; bytes before the first
// first_byte or after a verdict are dropped silently. Write the transaction
// ID registers only while no message is in flight.
module stun_binding_response_parser import sbrp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_t        out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  logic [95:0] txid;
  logic        res_valid;
  logic        res_free;
  out_t        res_data;

  assign cfg_ready_o = 1'b1;

  sbrp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .txid_o      (txid)
  );

  sbrp_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .txid_i      (txid),
    .res_free_i  (res_free),
    .res_valid_o (res_valid),
    .res_data_o  (res_data)
  );

  sbrp_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_data_i  (res_data),
    .res_free_o  (res_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

`ifndef ASSERT_OFF
  a_res_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |-> (!out_valid_o || out_ready_i))
    else $error("result produced with no room in output register");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status <= ST_TRUNC))
    else $error("status code out of range");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != ST_FOUND) |->
      (out_data_o.address_kind == 1'b0 && out_data_o.ipv4_address == '0
       && out_data_o.port_number == '0))
    else $error("error verdict carries address fields");

  a_res_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid |=> (out_valid_o && out_data_o == $past(res_data)))
    else $error("result not captured in output register");
`endif

endmodule

>>> rtl/core/sbrp_cfg_regs.sv
// ----------------------------------------------------------------------------
// sbrp_cfg_regs
// Transaction ID registers of the outstanding request.
// ----------------------------------------------------------------------------
module sbrp_cfg_regs import sbrp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output logic [95:0] txid_o
);

  logic [31:0] head_q, head_d;
  logic [63:0] tail_q, tail_d;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_TXID_HEAD: head_d = cfg_data_i[31:0];
        CFG_TXID_TAIL: tail_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  assign txid_o = {head_q, tail_q};

endmodule

>>> rtl/core/sbrp_parser.sv
// ----------------------------------------------------------------------------
// sbrp_parser
// Input byte register and the per-byte header and attribute walk.
// ----------------------------------------------------------------------------
module sbrp_parser import sbrp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_t         in_data_i,
  input  logic [95:0] txid_i,
  input  logic        res_free_i,
  output logic        res_valid_o,
  output out_t        res_data_o
);

  logic      s1_valid_q, s1_valid_d;
  in_t       s1_data_q;
  parse_st_t st_q, st_d;

  parse_st_t cur, nxt;
  logic      hit;
  logic [2:0] hit_status;
  logic      hit_kind;
  logic      s1_go;

  // next state for one byte
  always_comb begin
    logic [7:0]  b;
    logic [3:0]  k;
    logic [6:0]  lsb;
    logic [16:0] off_inc;
    logic [16:0] padded;
    logic [15:0] cnt_inc;
    logic        is_addr;
    b          = s1_data_q.rx_byte;
    cur        = st_q;
    if (s1_data_q.first_byte) begin
      cur       = '0;
      cur.phase = PH_HEADER;
    end
    nxt        = cur;
    hit        = 1'b0;
    hit_status = ST_FOUND;
    hit_kind   = 1'b0;
    k          = '0;
    lsb        = '0;
    off_inc    = 17'({1'b0, cur.attr_off} + 17'd1);
    padded     = 17'(({1'b0, cur.attr_len} + 17'd3) & ~17'd3);
    cnt_inc    = cur.body_cnt + 16'd1;
    is_addr    = (cur.attr_type == ATTR_MAPPED) || (cur.attr_type == ATTR_XOR_MAPPED);

    unique case (cur.phase)
      PH_HEADER: begin
        if (cur.hdr_idx < 5'd2) begin
          nxt.attr_type = {cur.attr_type[7:0], b};
          if (cur.hdr_idx == 5'd1 && nxt.attr_type != MSG_TYPE_BIND_RESP) begin
            hit        = 1'b1;
            hit_status = ST_TYPE;
          end
        end else if (cur.hdr_idx < 5'd4) begin
          nxt.msg_len = {cur.msg_len[7:0], b};
        end else if (cur.hdr_idx < 5'd8) begin
          nxt.addr = {cur.addr[23:0], b};
          if (cur.hdr_idx == 5'd7 && nxt.addr != STUN_COOKIE) begin
            hit        = 1'b1;
            hit_status = ST_COOKIE;
          end
        end else begin
          k   = 4'(cur.hdr_idx - 5'd8);
          lsb = {4'd11 - k, 3'b000};
          if (b != txid_i[lsb +: 8]) begin
            hit        = 1'b1;
            hit_status = ST_ID;
          end
        end
        if (!hit) begin
          nxt.hdr_idx = cur.hdr_idx + 5'd1;
          if (nxt.hdr_idx == HDR_BYTES) begin
            nxt.phase    = PH_ATTR_HDR;
            nxt.attr_off = '0;
            nxt.body_cnt = '0;
            if (nxt.msg_len == '0) begin
              hit        = 1'b1;
              hit_status = ST_NOADDR;
            end
          end
        end
      end
      PH_ATTR_HDR, PH_ATTR_VAL: begin
        if (cur.phase == PH_ATTR_HDR) begin
          if (cur.attr_off < 16'd2) begin
            nxt.attr_type = {cur.attr_type[7:0], b};
          end else begin
            nxt.attr_len = {cur.attr_len[7:0], b};
          end
          if (off_inc == 17'd4) begin
            nxt.attr_off = '0;
            nxt.family   = '0;
            nxt.port     = '0;
            nxt.addr     = '0;
            if (nxt.attr_len != '0) begin
              nxt.phase = PH_ATTR_VAL;
            end
          end else begin
            nxt.attr_off = off_inc[15:0];
          end
        end else begin
          if (is_addr) begin
            if (cur.attr_off == 16'd1) begin
              nxt.family = b;
            end else if (cur.attr_off == 16'd2 || cur.attr_off == 16'd3) begin
              nxt.port = {cur.port[7:0], b};
            end else if (cur.attr_off >= 16'd4 && cur.attr_off <= 16'd7) begin
              nxt.addr = {cur.addr[23:0], b};
            end
            if (cur.attr_off == 16'd7 && cur.family == FAMILY_IPV4
                && cur.attr_len >= 16'd8) begin
              hit        = 1'b1;
              hit_status = ST_FOUND;
              hit_kind   = (cur.attr_type == ATTR_XOR_MAPPED);
            end
          end
          if (!hit) begin
            if (off_inc >= padded) begin
              nxt.attr_off = '0;
              nxt.phase    = PH_ATTR_HDR;
            end else begin
              nxt.attr_off = off_inc[15:0];
            end
          end
        end
        if (!hit) begin
          nxt.body_cnt = cnt_inc;
          if (cnt_inc == cur.msg_len) begin
            hit        = 1'b1;
            hit_status = ST_NOADDR;
          end
        end
      end
      default: ;
    endcase

    if (!hit && s1_data_q.last_byte && (cur.phase == PH_HEADER
        || cur.phase == PH_ATTR_HDR || cur.phase == PH_ATTR_VAL)) begin
      hit        = 1'b1;
      hit_status = ST_TRUNC;
    end
    if (hit) begin
      nxt.phase = PH_DONE;
    end
  end

  // result fields
  always_comb begin
    res_data_o = '0;
    res_data_o.status = hit_status;
    if (hit_status == ST_FOUND) begin
      res_data_o.address_kind = hit_kind;
      res_data_o.ipv4_address = hit_kind ? (nxt.addr ^ STUN_COOKIE) : nxt.addr;
      res_data_o.port_number  = hit_kind ? (nxt.port ^ COOKIE_HI) : nxt.port;
    end
  end

  assign s1_go       = s1_valid_q && (!hit || res_free_i);
  assign res_valid_o = s1_valid_q && hit && res_free_i;
  assign in_ready_o  = !s1_valid_q || s1_go;
  assign st_d        = s1_go ? nxt : st_q;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_valid_i && in_ready_o) begin
      s1_valid_d = 1'b1;
    end else if (s1_go) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      st_q       <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      st_q       <= st_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_data_q <= in_data_i;
    end
  end

endmodule

>>> rtl/core/sbrp_out_reg.sv
// ----------------------------------------------------------------------------
// sbrp_out_reg
// Result register toward the consumer.
// ----------------------------------------------------------------------------
module sbrp_out_reg import sbrp_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic res_valid_i,
  input  out_t res_data_i,
  output logic res_free_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic out_valid_q, out_valid_d;
  out_t out_data_q;

  assign res_free_o = !out_valid_q || out_ready_i;

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_valid_i) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid_i) begin
      out_data_q <= res_data_i;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
